@@ design/cfp_pkg.sv @@
// Shared types and constants for the checksum frame parser.
package cfp_pkg;

    localparam int MAX_PAYLOAD = 1016;
    localparam int INDEX_W     = 10;
    localparam int LENGTH_W    = 16;

    localparam logic [LENGTH_W-1:0] MAX_PAYLOAD_LEN = LENGTH_W'(MAX_PAYLOAD);

    // Parser phases
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_START_OK  = 4'd1;
    localparam logic [3:0] PH_START_BAD = 4'd2;
    localparam logic [3:0] PH_CMD       = 4'd3;
    localparam logic [3:0] PH_LEN_HI    = 4'd4;
    localparam logic [3:0] PH_LEN_LO    = 4'd5;
    localparam logic [3:0] PH_PAYLOAD   = 4'd6;
    localparam logic [3:0] PH_SUM       = 4'd7;
    localparam logic [3:0] PH_STOP_ONE  = 4'd8;
    localparam logic [3:0] PH_STOP_TWO  = 4'd9;
    localparam logic [3:0] PH_DONE      = 4'd10;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_START = 3'd1;
    localparam logic [2:0] ERR_BAD_STOP  = 3'd2;
    localparam logic [2:0] ERR_BAD_SUM   = 3'd3;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_FIRST  = 2'd0;
    localparam logic [1:0] CFG_START_SECOND = 2'd1;
    localparam logic [1:0] CFG_STOP_FIRST   = 2'd2;
    localparam logic [1:0] CFG_STOP_SECOND  = 2'd3;

    typedef struct packed {
        logic [7:0] start_first;
        logic [7:0] start_second;
        logic [7:0] stop_first;
        logic [7:0] stop_second;
    } cfp_cfg_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          command;
        logic [7:0]          payload_byte;
        logic [INDEX_W-1:0]  payload_index;
        logic [LENGTH_W-1:0] frame_length;
        logic [2:0]          error_code;
    } cfp_result_t;

endpackage

@@ design/checksum_frame_parser.sv @@
// Top level of the checksum frame parser: config registers, parser core, result register.
//
// Usage:
//   Input beats (s_valid/s_ready) carry one received byte each; s_chunk_first
//   marks the first byte of a new chunk, which starts a new frame. A frame is
//   two start bytes, command, 16-bit big-endian length, payload, additive
//   8-bit checksum and two stop bytes. Each payload byte comes out as a
//   result beat (kind payload) with its command and index, and each frame
//   ends in one verdict beat: accepted or rejected with an error code.
//   Marker bytes are set through cfg_wr_en/cfg_index/cfg_data while idle.
//   A result appears on m_* in the cycle after the byte that caused it.
//   Throughput: one byte per cycle unless stalled; the parser state and checksum
//   update in the accept cycle and the result lands in a single output register.
//   When the receiver stalls with a result held, s_ready drops until that
//   result is taken; bytes causing no result still need that slot free.
//   Reset (aresetn low, synchronous) clears the parser to wait for a chunk,
//   empties the output register and sets all marker bytes to zero.
module checksum_frame_parser import cfp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_byte_value,
    input  logic                s_chunk_first,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_result_kind,
    output logic [7:0]          m_command,
    output logic [7:0]          m_payload_byte,
    output logic [INDEX_W-1:0]  m_payload_index,
    output logic [LENGTH_W-1:0] m_frame_length,
    output logic [2:0]          m_error_code
);

    cfp_cfg_t    cfg_reg, cfg_next;
    cfp_result_t res;
    cfp_result_t out_reg;
    logic        res_valid;
    logic        beat_en;
    logic        m_valid_reg, m_valid_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_START_FIRST:  cfg_next.start_first  = cfg_data;
                CFG_START_SECOND: cfg_next.start_second = cfg_data;
                CFG_STOP_FIRST:   cfg_next.stop_first   = cfg_data;
                CFG_STOP_SECOND:  cfg_next.stop_second  = cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign beat_en = s_valid && s_ready;

    cfp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_en     (beat_en),
        .byte_value  (s_byte_value),
        .chunk_first (s_chunk_first),
        .cfg         (cfg_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_comb begin
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = out_reg.kind;
    assign m_command       = out_reg.command;
    assign m_payload_byte  = out_reg.payload_byte;
    assign m_payload_index = out_reg.payload_index;
    assign m_frame_length  = out_reg.frame_length;
    assign m_error_code    = out_reg.error_code;

`ifndef SYNTHESIS
    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> m_valid_reg && out_reg == $past(res))
        else $error("result beat not captured");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !res_valid)
        else $error("held result would be overwritten");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_ready && !res_valid |=> !m_valid_reg)
        else $error("taken result beat repeated");
`endif

endmodule

@@ design/cfp_core.sv @@
// Frame parsing state machine and running checksum, one byte per beat.
module cfp_core import cfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        beat_en,
    input  logic [7:0]  byte_value,
    input  logic        chunk_first,
    input  cfp_cfg_t    cfg,
    output logic        res_valid,
    output cfp_result_t res
);

    logic [3:0]          phase_reg,    phase_next;
    logic [7:0]          command_reg,  command_next;
    logic [LENGTH_W-1:0] length_reg,   length_next;
    logic [INDEX_W-1:0]  seen_reg,     seen_next;
    logic [7:0]          sum_reg,      sum_next;
    logic                matched_reg,  matched_next;
    logic                res_hit;
    logic [INDEX_W-1:0]  seen_inc;

    assign seen_inc = seen_reg + INDEX_W'(1);

    always_comb begin
        phase_next   = phase_reg;
        command_next = command_reg;
        length_next  = length_reg;
        seen_next    = seen_reg;
        sum_next     = sum_reg;
        matched_next = matched_reg;
        res_hit      = 1'b0;
        res          = '0;
        res.command  = command_reg;

        if (chunk_first) begin
            // unfinished frame gets a truncated verdict with what was seen so far
            if (phase_reg >= PH_START_OK && phase_reg <= PH_STOP_TWO) begin
                res_hit        = 1'b1;
                res.kind       = KIND_REJECT;
                res.error_code = ERR_TRUNCATED;
            end
            command_next = '0;
            length_next  = '0;
            seen_next    = '0;
            sum_next     = byte_value;
            matched_next = 1'b0;
            phase_next   = (byte_value == cfg.start_first) ? PH_START_OK : PH_START_BAD;
        end else begin
            case (phase_reg)
                PH_START_OK, PH_START_BAD: begin
                    sum_next = sum_reg + byte_value;
                    if (phase_reg == PH_START_OK && byte_value == cfg.start_second) begin
                        phase_next = PH_CMD;
                    end else begin
                        res_hit        = 1'b1;
                        res.kind       = KIND_REJECT;
                        res.error_code = ERR_BAD_START;
                        phase_next     = PH_DONE;
                    end
                end
                PH_CMD: begin
                    command_next = byte_value;
                    sum_next     = sum_reg + byte_value;
                    phase_next   = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    length_next = {byte_value, 8'h00};
                    sum_next    = sum_reg + byte_value;
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    length_next = {length_reg[15:8], byte_value};
                    sum_next    = sum_reg + byte_value;
                    if (length_next > MAX_PAYLOAD_LEN) begin
                        res_hit        = 1'b1;
                        res.kind       = KIND_REJECT;
                        res.error_code = ERR_TOO_LONG;
                        phase_next     = PH_DONE;
                    end else if (length_next != '0) begin
                        phase_next = PH_PAYLOAD;
                    end else begin
                        phase_next = PH_SUM;
                    end
                end
                PH_PAYLOAD: begin
                    res_hit           = 1'b1;
                    res.kind          = KIND_PAYLOAD;
                    res.payload_byte  = byte_value;
                    res.payload_index = seen_reg;
                    sum_next          = sum_reg + byte_value;
                    seen_next         = seen_inc;
                    if ({{(LENGTH_W-INDEX_W){1'b0}}, seen_inc} >= length_reg) begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM: begin
                    matched_next = (byte_value == sum_reg);
                    phase_next   = PH_STOP_ONE;
                end
                PH_STOP_ONE: begin
                    if (byte_value != cfg.stop_first) begin
                        res_hit        = 1'b1;
                        res.kind       = KIND_REJECT;
                        res.error_code = ERR_BAD_STOP;
                        phase_next     = PH_DONE;
                    end else begin
                        phase_next = PH_STOP_TWO;
                    end
                end
                PH_STOP_TWO: begin
                    res_hit = 1'b1;
                    // stop bytes are judged before the checksum
                    priority if (byte_value != cfg.stop_second) begin
                        res.kind       = KIND_REJECT;
                        res.error_code = ERR_BAD_STOP;
                    end else if (!matched_reg) begin
                        res.kind       = KIND_REJECT;
                        res.error_code = ERR_BAD_SUM;
                    end else begin
                        res.kind       = KIND_ACCEPT;
                        res.error_code = ERR_NONE;
                    end
                    phase_next = PH_DONE;
                end
                default: begin
                    // idle or after a verdict: byte is dropped
                end
            endcase
        end
        // length field shows the header as received, low byte included
        res.frame_length = chunk_first ? length_reg : length_next;
    end

    assign res_valid = beat_en && res_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            command_reg <= '0;
            length_reg  <= '0;
            seen_reg    <= '0;
            sum_reg     <= '0;
            matched_reg <= 1'b0;
        end else if (beat_en) begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            seen_reg    <= seen_next;
            sum_reg     <= sum_next;
            matched_reg <= matched_next;
        end
    end

`ifndef SYNTHESIS
    a_first_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_en && chunk_first |=> phase_reg == PH_START_OK || phase_reg == PH_START_BAD)
        else $error("chunk start did not restart the parser");

    a_payload_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |->
            {{(LENGTH_W-INDEX_W){1'b0}}, seen_reg} < length_reg &&
            length_reg <= MAX_PAYLOAD_LEN)
        else $error("payload counter out of range");

    a_accept_at_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.kind == KIND_ACCEPT |->
            phase_reg == PH_STOP_TWO && res.error_code == ERR_NONE && matched_reg)
        else $error("frame accepted outside of second stop byte");

    a_done_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_en && !chunk_first && (phase_reg == PH_DONE || phase_reg == PH_IDLE)
            |-> !res_valid)
        else $error("result produced while waiting for a chunk");
`endif

endmodule

@@ tb/tb_checksum_frame_parser.sv @@
// Self-checking testbench for the checksum frame parser: random framed byte traffic.
`timescale 1ns / 1ps

module tb_checksum_frame_parser;
    import cfp_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_PRINTED = 40;

    typedef enum {
        FLAW_NONE, FLAW_START1, FLAW_START2, FLAW_SUM, FLAW_STOP1, FLAW_STOP2,
        FLAW_SUM_STOP, FLAW_LONG, FLAW_CUT
    } frame_flaw_e;

    typedef enum {READY_ALWAYS, READY_MOSTLY, READY_PERIODIC, READY_COIN} ready_mode_e;

    typedef struct {
        logic [7:0] value;
        logic       first;
    } rx_beat_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [1:0]          cfg_index = CFG_START_FIRST;
    logic [7:0]          cfg_data = 8'h00;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [7:0]          s_byte_value = 8'h00;
    logic                s_chunk_first = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [1:0]          m_result_kind;
    logic [7:0]          m_command;
    logic [7:0]          m_payload_byte;
    logic [INDEX_W-1:0]  m_payload_index;
    logic [LENGTH_W-1:0] m_frame_length;
    logic [2:0]          m_error_code;

    checksum_frame_parser dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_value    (s_byte_value),
        .s_chunk_first   (s_chunk_first),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_command       (m_command),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_frame_length  (m_frame_length),
        .m_error_code    (m_error_code)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Parser model state
    cfp_cfg_t            marker_cfg = '0;
    logic [3:0]          fp_phase = PH_IDLE;
    logic [7:0]          fp_command = 8'h00;
    logic [LENGTH_W-1:0] fp_length = '0;
    logic [15:0]         fp_seen = '0;
    logic [7:0]          fp_sum = 8'h00;
    logic                fp_sum_ok = 1'b0;

    cfp_result_t expected_results[$];
    rx_beat_t    byte_queue[$];

    int unsigned beats_queued = 0;
    int unsigned ignored_queued = 0;
    int unsigned beats_accepted = 0;
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned ready_cycle = 0;
    ready_mode_e ready_mode = READY_ALWAYS;
    logic        in_beat_taken = 1'b0;
    rx_beat_t    next_beat;
    cfp_result_t seen_result;
    cfp_result_t want_result;

    task automatic note_error(string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR %0t: %s", $time, msg);
    endtask

    function automatic void expect_result(logic [1:0] kind, logic [7:0] pbyte,
                                          logic [INDEX_W-1:0] pidx, logic [2:0] err);
        cfp_result_t r;
        r.kind          = kind;
        r.command       = fp_command;
        r.payload_byte  = pbyte;
        r.payload_index = pidx;
        r.frame_length  = fp_length;
        r.error_code    = err;
        expected_results.push_back(r);
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic first);
        if (first) begin
            // a new chunk cuts off any frame still open
            if (fp_phase >= PH_START_OK && fp_phase <= PH_STOP_TWO)
                expect_result(KIND_REJECT, 8'h00, '0, ERR_TRUNCATED);
            fp_command = 8'h00;
            fp_length  = '0;
            fp_seen    = '0;
            fp_sum     = b;
            fp_sum_ok  = 1'b0;
            fp_phase   = (b == marker_cfg.start_first) ? PH_START_OK : PH_START_BAD;
            return;
        end
        case (fp_phase)
            PH_START_OK, PH_START_BAD: begin
                fp_sum = fp_sum + b;
                if (fp_phase == PH_START_OK && b == marker_cfg.start_second) begin
                    fp_phase = PH_CMD;
                end else begin
                    expect_result(KIND_REJECT, 8'h00, '0, ERR_BAD_START);
                    fp_phase = PH_DONE;
                end
            end
            PH_CMD: begin
                fp_command = b;
                fp_sum     = fp_sum + b;
                fp_phase   = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                fp_length = {b, 8'h00};
                fp_sum    = fp_sum + b;
                fp_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                fp_length = {fp_length[15:8], b};
                fp_sum    = fp_sum + b;
                if (fp_length > MAX_PAYLOAD_LEN) begin
                    expect_result(KIND_REJECT, 8'h00, '0, ERR_TOO_LONG);
                    fp_phase = PH_DONE;
                end else begin
                    fp_phase = (fp_length != 0) ? PH_PAYLOAD : PH_SUM;
                end
            end
            PH_PAYLOAD: begin
                expect_result(KIND_PAYLOAD, b, fp_seen[INDEX_W-1:0], ERR_NONE);
                fp_sum  = fp_sum + b;
                fp_seen = fp_seen + 16'd1;
                if (fp_seen >= fp_length)
                    fp_phase = PH_SUM;
            end
            PH_SUM: begin
                fp_sum_ok = (b == fp_sum);
                fp_phase  = PH_STOP_ONE;
            end
            PH_STOP_ONE: begin
                if (b != marker_cfg.stop_first) begin
                    expect_result(KIND_REJECT, 8'h00, '0, ERR_BAD_STOP);
                    fp_phase = PH_DONE;
                end else begin
                    fp_phase = PH_STOP_TWO;
                end
            end
            PH_STOP_TWO: begin
                // stop markers take precedence over the checksum verdict
                if (b != marker_cfg.stop_second)
                    expect_result(KIND_REJECT, 8'h00, '0, ERR_BAD_STOP);
                else if (!fp_sum_ok)
                    expect_result(KIND_REJECT, 8'h00, '0, ERR_BAD_SUM);
                else
                    expect_result(KIND_ACCEPT, 8'h00, '0, ERR_NONE);
                fp_phase = PH_DONE;
            end
            default: ;
        endcase
    endfunction

    // Sender: bursts of beats separated by random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_beat_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
                next_beat = byte_queue.pop_front();
                s_valid       <= 1'b1;
                s_byte_value  <= next_beat.value;
                s_chunk_first <= next_beat.first;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 32);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: m_ready follows a stall pattern that is re-picked at random
    always @(negedge aclk) begin
        ready_cycle++;
        if (ready_cycle % 256 == 0)
            ready_mode = ready_mode_e'($urandom_range(READY_ALWAYS, READY_COIN));
        case (ready_mode)
            READY_ALWAYS:   m_ready <= 1'b1;
            READY_MOSTLY:   m_ready <= ($urandom_range(0, 3) != 0);
            READY_PERIODIC: m_ready <= ((ready_cycle % 7) < 4);
            default:        m_ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    // Monitor: check result beats first, then predict from the accepted input beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_beat_taken <= 1'b0;
        end else begin
            in_beat_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                seen_result = '{m_result_kind, m_command, m_payload_byte,
                                m_payload_index, m_frame_length, m_error_code};
                if (expected_results.size() == 0) begin
                    note_error($sformatf("unexpected result beat %p", seen_result));
                end else begin
                    want_result = expected_results.pop_front();
                    if (seen_result.kind !== want_result.kind)
                        note_error($sformatf("kind %0d, want %0d",
                                             seen_result.kind, want_result.kind));
                    if (seen_result.command !== want_result.command)
                        note_error($sformatf("command %h, want %h",
                                             seen_result.command, want_result.command));
                    if (seen_result.payload_byte !== want_result.payload_byte)
                        note_error($sformatf("payload_byte %h, want %h",
                                             seen_result.payload_byte,
                                             want_result.payload_byte));
                    if (seen_result.payload_index !== want_result.payload_index)
                        note_error($sformatf("payload_index %0d, want %0d",
                                             seen_result.payload_index,
                                             want_result.payload_index));
                    if (seen_result.frame_length !== want_result.frame_length)
                        note_error($sformatf("frame_length %0d, want %0d",
                                             seen_result.frame_length,
                                             want_result.frame_length));
                    if (seen_result.error_code !== want_result.error_code)
                        note_error($sformatf("error_code %0d, want %0d",
                                             seen_result.error_code,
                                             want_result.error_code));
                end
            end
            if (s_valid && s_ready) begin
                parse_byte(s_byte_value, s_chunk_first);
                beats_accepted++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_checksum_frame_parser: errors");
            $finish;
        end
    end

    function automatic logic [7:0] flip_mask();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic void queue_byte(logic [7:0] value, logic first);
        rx_beat_t beat;
        beat.value = value;
        beat.first = first;
        byte_queue.push_back(beat);
        beats_queued++;
    endfunction

    function automatic void queue_frame(logic [7:0] cmd, logic [15:0] len,
                                        frame_flaw_e flaw, int unsigned tail);
        logic [7:0]  fb[$];
        logic [7:0]  sum;
        int unsigned keep;
        fb.push_back(marker_cfg.start_first);
        fb.push_back(marker_cfg.start_second);
        fb.push_back(cmd);
        fb.push_back(len[15:8]);
        fb.push_back(len[7:0]);
        if (flaw == FLAW_START1) fb[0] = fb[0] ^ flip_mask();
        if (flaw == FLAW_START2) fb[1] = fb[1] ^ flip_mask();
        if (flaw != FLAW_LONG) begin
            for (int i = 0; i < len; i++)
                fb.push_back(8'($urandom_range(0, 255)));
            sum = 8'h00;
            foreach (fb[i]) sum = sum + fb[i];
            if (flaw == FLAW_SUM || flaw == FLAW_SUM_STOP) sum = sum ^ flip_mask();
            fb.push_back(sum);
            fb.push_back(marker_cfg.stop_first ^ ((flaw == FLAW_STOP1) ? flip_mask() : 8'h00));
            fb.push_back(marker_cfg.stop_second ^
                         ((flaw == FLAW_STOP2 || flaw == FLAW_SUM_STOP) ? flip_mask() : 8'h00));
        end
        keep = fb.size();
        if (flaw == FLAW_CUT) keep = $urandom_range(1, fb.size() - 1);
        for (int i = 0; i < keep; i++)
            queue_byte(fb[i], i == 0);
        // bytes after the verdict are dropped by the parser
        if (flaw != FLAW_CUT) begin
            repeat (tail) begin
                queue_byte(8'($urandom_range(0, 255)), 1'b0);
                ignored_queued++;
            end
        end
    endfunction

    task automatic write_marker(logic [1:0] idx, logic [7:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_START_FIRST:  marker_cfg.start_first  = value;
            CFG_START_SECOND: marker_cfg.start_second = value;
            CFG_STOP_FIRST:   marker_cfg.stop_first   = value;
            default:          marker_cfg.stop_second  = value;
        endcase
    endtask

    task automatic set_markers(logic [7:0] s1, logic [7:0] s2, logic [7:0] e1, logic [7:0] e2);
        write_marker(CFG_START_FIRST, s1);
        write_marker(CFG_START_SECOND, s2);
        write_marker(CFG_STOP_FIRST, e1);
        write_marker(CFG_STOP_SECOND, e2);
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        while (beats_accepted != beats_queued || expected_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic random_traffic(int unsigned budget);
        int unsigned base;
        int unsigned pick;
        logic [15:0] len;
        frame_flaw_e flaw;
        base = beats_queued - ignored_queued;
        while (beats_queued - ignored_queued - base < budget) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(11, 64))
                                                : 16'($urandom_range(0, 10));
            if (pick < 65) begin
                queue_frame(8'($urandom_range(0, 255)), len, FLAW_NONE,
                            ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            end else if (pick < 93) begin
                flaw = frame_flaw_e'($urandom_range(FLAW_START1, FLAW_CUT));
                if (flaw == FLAW_LONG) len = 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
                queue_frame(8'($urandom_range(0, 255)), len, flaw, $urandom_range(0, 2));
            end else begin
                repeat ($urandom_range(1, 4))
                    queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // markers still at reset value: stray bytes before any chunk, then an all-zero frame
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h5A, 1'b0);
        queue_frame(8'h00, 16'd0, FLAW_NONE, 0);
        wait_idle();

        set_markers(8'hAA, 8'h55, 8'h0D, 8'h0A);
        queue_frame(8'hFF, 16'd1, FLAW_NONE, 2);
        queue_frame(8'h01, 16'd3, FLAW_START1, 0);
        queue_frame(8'h02, 16'd3, FLAW_START2, 0);
        queue_frame(8'h03, 16'd2, FLAW_SUM, 0);
        queue_frame(8'h04, 16'd2, FLAW_STOP1, 0);
        queue_frame(8'h05, 16'd0, FLAW_STOP2, 0);
        queue_frame(8'h06, 16'd1, FLAW_SUM_STOP, 0);
        queue_frame(8'h07, 16'(MAX_PAYLOAD + 1), FLAW_LONG, 1);
        queue_frame(8'h08, 16'hFFFF, FLAW_LONG, 0);
        queue_frame(8'h09, 16'd4, FLAW_CUT, 0);
        queue_frame(8'h0A, 16'(MAX_PAYLOAD), FLAW_NONE, 0);
        wait_idle();

        set_markers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        random_traffic(215);
        wait_idle();

        set_markers(8'h00, 8'h00, 8'h00, 8'h00);
        random_traffic(215);
        wait_idle();

        repeat (2) begin
            set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            random_traffic(210);
            wait_idle();
        end

        repeat (10) @(negedge aclk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb_checksum_frame_parser: clean");
        else
            $display("tb_checksum_frame_parser: errors");
        $finish;
    end

endmodule
